@@ hdl/mexp_pkg.sv @@
package mexp_pkg;

	// operand and modulus width
	localparam int VALUE_WIDTH = 16;
	// bit counter for the serial multiplier and the exponent scan
	localparam int CNT_WIDTH = $clog2(VALUE_WIDTH);
	// configuration index width, wide enough to see writes past the register list
	localparam int CFG_INDEX_WIDTH = 2;

	typedef logic [VALUE_WIDTH-1:0] value_t;
	typedef logic [CFG_INDEX_WIDTH-1:0] cfg_index_t;

	// configuration register indexes
	localparam cfg_index_t REG_EXPONENT = cfg_index_t'(0);
	localparam cfg_index_t REG_MODULUS  = cfg_index_t'(1);

	// request into the modular multiplier
	typedef struct packed {
		logic   start;
		value_t a;
		value_t b;
	} mm_req_t;

	// status out of the modular multiplier
	typedef struct packed {
		logic busy;
		logic done;
	} mm_sts_t;

endpackage

@@ hdl/mexp_modmul.sv @@
module mexp_modmul (
	input  logic              clk,
	input  logic              arst_n,
	input  mexp_pkg::mm_req_t req,
	input  mexp_pkg::value_t  modulus,
	output mexp_pkg::mm_sts_t sts,
	output mexp_pkg::value_t  product
);
	import mexp_pkg::*;

	logic                   busy_q;
	logic                   done_q;
	logic [CNT_WIDTH-1:0]   cnt_q;
	value_t                 r_q;
	value_t                 a_q;
	value_t                 b_q;
	logic [VALUE_WIDTH+1:0] sum;
	logic [VALUE_WIDTH+1:0] n1;
	logic [VALUE_WIDTH+1:0] n2;
	value_t                 r_next;

	// one multiplier bit per cycle, msb first: r = 2r + bit*a, then bring back below n
	always_comb begin
		n1  = {2'b00, modulus};
		n2  = {1'b0, modulus, 1'b0};
		sum = {1'b0, r_q, 1'b0} + (b_q[VALUE_WIDTH-1] ? {2'b00, a_q} : '0);
		if (sum >= n2) begin
			r_next = VALUE_WIDTH'(sum - n2);
		end else if (sum >= n1) begin
			r_next = VALUE_WIDTH'(sum - n1);
		end else begin
			r_next = VALUE_WIDTH'(sum);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= CNT_WIDTH'(VALUE_WIDTH - 1);
			end else if (busy_q) begin
				if (cnt_q == '0) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end else begin
					cnt_q <= cnt_q - CNT_WIDTH'(1);
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			r_q <= '0;
			a_q <= req.a;
			b_q <= req.b;
		end else if (busy_q) begin
			r_q <= r_next;
			b_q <= b_q << 1;
		end
	end

	assign sts.busy = busy_q;
	assign sts.done = done_q;
	assign product  = r_q;

endmodule

@@ hdl/modular_exponentiation.sv @@
// Modular exponentiation: each request carries value_in and returns one response,
// value_out = value_in ^ exponent mod modulus, with exponent and modulus taken from the
// configuration registers (index 0 exponent, reset 1; index 1 modulus, reset 2). A zero
// exponent always answers 1, a modulus of 0 or 1 with a nonzero exponent answers 0.
// All arithmetic runs on one bit-serial modular multiplier. A request is taken in the idle
// state, then one product reduces the value below the modulus, then one step state per
// exponent bit down to and including the leading one, then for every lower bit a step plus
// a squaring plus, for a set bit, a multiply, and finally the output state loads the output
// register once it is free. The zero-exponent case and a modulus below two go straight
// from the idle state to the output state.
// req_stall is high for the whole computation; a finished result sits in the output
// register, so the next request can be taken while the response is still stalled.
// Configuration writes are always taken (cfg_ready is tied high) and must only be
// issued while no request is in flight.
module modular_exponentiation (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_valid,
	output logic                 cfg_ready,
	input  mexp_pkg::cfg_index_t cfg_index,
	input  mexp_pkg::value_t     cfg_data,
	input  logic                 req_valid,
	output logic                 req_stall,
	input  mexp_pkg::value_t     value_in,
	output logic                 rsp_valid,
	input  logic                 rsp_stall,
	output mexp_pkg::value_t     value_out
);
	import mexp_pkg::*;

	// sequencer states
	localparam logic [2:0] ST_IDLE   = 3'd0;
	localparam logic [2:0] ST_REDUCE = 3'd1;
	localparam logic [2:0] ST_STEP   = 3'd2;
	localparam logic [2:0] ST_SQUARE = 3'd3;
	localparam logic [2:0] ST_MULT   = 3'd4;
	localparam logic [2:0] ST_OUT    = 3'd5;

	// configuration registers
	value_t               exponent_q;
	value_t               modulus_q;

	// sequencer
	logic [2:0]           state_q;
	logic [2:0]           state_d;
	logic                 started_q;
	logic                 started_d;
	logic [CNT_WIDTH-1:0] bit_q;
	logic [CNT_WIDTH-1:0] bit_d;
	logic                 last_bit;
	logic                 accept;
	logic                 load_out;

	// datapath
	value_t               acc_q;
	value_t               acc_d;
	value_t               base_q;
	value_t               base_d;
	value_t               value_out_q;
	logic                 rsp_valid_q;

	// shared multiplier
	mm_req_t              mm_req;
	mm_sts_t              mm_sts;
	value_t               mm_product;

	assign cfg_ready = 1'b1;

	// configuration write port
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			exponent_q <= value_t'(1);
			modulus_q  <= value_t'(2);
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				REG_EXPONENT: exponent_q <= cfg_data;
				REG_MODULUS:  modulus_q  <= cfg_data;
				default: ;
			endcase
		end
	end

	assign req_stall = (state_q != ST_IDLE);
	assign accept    = req_valid && !req_stall;
	assign last_bit  = (bit_q == '0);

	// request into the multiplier: reduce, square or multiply by the base
	always_comb begin
		mm_req.start = 1'b0;
		mm_req.a     = acc_q;
		mm_req.b     = acc_q;
		case (state_q)
			ST_IDLE: begin
				// base mod n computed as 1 * value_in
				if (accept && exponent_q != '0 && modulus_q > value_t'(1)) begin
					mm_req.start = 1'b1;
					mm_req.a     = value_t'(1);
					mm_req.b     = value_in;
				end
			end
			ST_STEP: begin
				mm_req.start = started_q;
			end
			ST_SQUARE: begin
				if (mm_sts.done && exponent_q[bit_q]) begin
					mm_req.start = 1'b1;
					mm_req.a     = mm_product;
					mm_req.b     = base_q;
				end
			end
			default: ;
		endcase
	end

	// square-and-multiply sequencer, msb of the exponent first
	always_comb begin
		state_d   = state_q;
		started_d = started_q;
		bit_d     = bit_q;
		acc_d     = acc_q;
		base_d    = base_q;
		load_out  = 1'b0;
		case (state_q)
			ST_IDLE: begin
				if (accept) begin
					base_d = value_in;
					if (exponent_q == '0) begin
						acc_d   = value_t'(1);
						state_d = ST_OUT;
					end else if (modulus_q <= value_t'(1)) begin
						acc_d   = '0;
						state_d = ST_OUT;
					end else begin
						state_d = ST_REDUCE;
					end
				end
			end
			ST_REDUCE: begin
				if (mm_sts.done) begin
					base_d    = mm_product;
					started_d = 1'b0;
					bit_d     = CNT_WIDTH'(VALUE_WIDTH - 1);
					state_d   = ST_STEP;
				end
			end
			ST_STEP: begin
				if (started_q) begin
					state_d = ST_SQUARE;
				end else begin
					// leading zeros leave the accumulator untouched, the first set bit loads the base
					if (exponent_q[bit_q]) begin
						acc_d     = base_q;
						started_d = 1'b1;
					end
					if (last_bit) begin
						state_d = ST_OUT;
					end else begin
						bit_d = bit_q - CNT_WIDTH'(1);
					end
				end
			end
			ST_SQUARE: begin
				if (mm_sts.done) begin
					acc_d = mm_product;
					if (exponent_q[bit_q]) begin
						state_d = ST_MULT;
					end else if (last_bit) begin
						state_d = ST_OUT;
					end else begin
						bit_d   = bit_q - CNT_WIDTH'(1);
						state_d = ST_STEP;
					end
				end
			end
			ST_MULT: begin
				if (mm_sts.done) begin
					acc_d = mm_product;
					if (last_bit) begin
						state_d = ST_OUT;
					end else begin
						bit_d   = bit_q - CNT_WIDTH'(1);
						state_d = ST_STEP;
					end
				end
			end
			ST_OUT: begin
				// wait for the output register to free up
				if (!rsp_valid_q || !rsp_stall) begin
					load_out = 1'b1;
					state_d  = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			started_q   <= 1'b0;
			bit_q       <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			state_q   <= state_d;
			started_q <= started_d;
			bit_q     <= bit_d;
			if (load_out) begin
				rsp_valid_q <= 1'b1;
			end else if (!rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		acc_q  <= acc_d;
		base_q <= base_d;
		if (load_out) begin
			value_out_q <= acc_q;
		end
	end

	mexp_modmul u_modmul (
		.clk     (clk),
		.arst_n  (arst_n),
		.req     (mm_req),
		.modulus (modulus_q),
		.sts     (mm_sts),
		.product (mm_product)
	);

	assign rsp_valid = rsp_valid_q;
	assign value_out = value_out_q;

`ifndef SYNTHESIS
	// the multiplier is never restarted while a product is in progress
	assert property (@(posedge clk) disable iff (!arst_n)
		mm_req.start |-> !mm_sts.busy)
		else $error("modmul started while busy");

	// a finished product only shows up while the sequencer waits for one
	assert property (@(posedge clk) disable iff (!arst_n)
		mm_sts.done |-> (state_q == ST_REDUCE || state_q == ST_SQUARE || state_q == ST_MULT))
		else $error("modmul done outside a multiply state");

	// leaving the output state always presents a response
	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_OUT && (!rsp_valid || !rsp_stall)) |=> rsp_valid)
		else $error("result not presented");

	// a reduced response stays below the modulus
	assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_valid && exponent_q != '0 && modulus_q > value_t'(1)) |-> value_out < modulus_q)
		else $error("response not reduced");
`endif

endmodule
